/* rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape.
package jsu_pkg;

    // Result status codes
    localparam logic [3:0] ST_DATA      = 4'd0;
    localparam logic [3:0] ST_DONE      = 4'd1;
    localparam logic [3:0] ST_NO_QUOTE  = 4'd2;
    localparam logic [3:0] ST_CTRL      = 4'd3;
    localparam logic [3:0] ST_ESC_END   = 4'd4;
    localparam logic [3:0] ST_BAD_U     = 4'd5;
    localparam logic [3:0] ST_BAD_PAIR  = 4'd6;
    localparam logic [3:0] ST_LONE_LOW  = 4'd7;
    localparam logic [3:0] ST_BAD_ESC   = 4'd8;
    localparam logic [3:0] ST_UNTERM    = 4'd9;

    // Command queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // One queue entry: up to four result bytes, or a single ending status
    typedef struct packed {
        logic [3:0][7:0] data;      // data[0] goes out first
        logic [1:0]      last_idx;  // index of final byte
        logic [3:0]      status;
    } jsu_entry_t;

    typedef struct packed {
        logic       valid;
        jsu_entry_t entry;
    } jsu_push_t;

endpackage

/* rtl/json_string_unescape.sv */
// Top level of the streaming JSON string unescaper; ties front, queue, back.
// Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
// A result passes through the queue write and then the output register before it is on
// the outputs. Throughput: one item per cycle in while in_stall is low; one result per
// cycle out while out_stall is low. A \u escape that yields 2 to 4 UTF-8 bytes holds
// the output for one result per byte; the four-entry queue absorbs these bursts, and
// in_stall rises only when it is full.
// Reset (rst_n low, async): parser idle awaiting a quote, queue and output empty.
module json_string_unescape
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel: one character byte per item
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic [3:0] status,
    output logic       last
);

    jsu_push_t  push;
    jsu_entry_t head;
    logic       q_full;
    logic       q_empty;
    logic       pop;
    logic       accept;

    // The front end never waits on the back end except through the queue:
    // each accepted item adds at most one entry, so "not full" is enough.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Front: phase tracking, escape and \u decoding, surrogate pairing,
    // UTF-8 encoding. Produces one entry per item that causes results.
    jsu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .push    (push)
    );

    // Decouples the parser from output backpressure.
    jsu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .empty (q_empty),
        .head  (head)
    );

    // Back: serializes entry bytes through the output register.
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (head),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule

/* rtl/jsu_front.sv */
// Front end: parses one byte per item and builds a result entry.
// Depends on jsu_pkg; feeds jsu_queue.
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output jsu_push_t  push
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_STR   = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_HEX   = 3'd3;
    localparam logic [2:0] PH_BSL   = 3'd4;
    localparam logic [2:0] PH_LU    = 3'd5;
    localparam logic [2:0] PH_HEXLO = 3'd6;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic jsu_entry_t utf8_entry(input logic [20:0] cp);
        jsu_entry_t e;
        e = '0;
        e.status = ST_DATA;
        if (cp < 21'h80) begin
            e.data[0]  = cp[7:0];
            e.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            e.data[0]  = {3'b110, cp[10:6]};
            e.data[1]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            e.data[0]  = {4'b1110, cp[15:12]};
            e.data[1]  = {2'b10, cp[11:6]};
            e.data[2]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd2;
        end else begin
            e.data[0]  = {5'b11110, cp[20:18]};
            e.data[1]  = {2'b10, cp[17:12]};
            e.data[2]  = {2'b10, cp[11:6]};
            e.data[3]  = {2'b10, cp[5:0]};
            e.last_idx = 2'd3;
        end
        return e;
    endfunction

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] accum_reg, accum_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  high_reg, high_next;

    logic        fin;
    logic [3:0]  fin_st;
    logic        emit;
    logic        raw;
    logic [20:0] cp;
    logic [4:0]  digit;
    logic [15:0] v;

    always_comb
    begin
        phase_next = phase_reg;
        accum_next = accum_reg;
        cnt_next   = cnt_reg;
        high_next  = high_reg;
        fin        = 1'b0;
        fin_st     = ST_DATA;
        emit       = 1'b0;
        raw        = 1'b0;
        cp         = '0;
        digit      = hex_digit(in_byte);
        v          = {accum_reg[11:0], digit[3:0]};
        push       = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_STR:
                begin
                    priority if (in_byte == CH_NUL) begin
                        fin = 1'b1; fin_st = ST_UNTERM;
                    end else if (in_byte == CH_QUOTE) begin
                        fin = 1'b1; fin_st = ST_DONE;
                    end else if (in_byte < CH_SPACE) begin
                        fin = 1'b1; fin_st = ST_CTRL;
                    end else if (in_byte == CH_BSL) begin
                        phase_next = PH_ESC;
                    end else begin
                        // plain byte goes out as is, top half included
                        emit = 1'b1; raw = 1'b1;
                    end
                end
                PH_ESC:
                begin
                    unique case (in_byte)
                        CH_NUL:   begin fin = 1'b1; fin_st = ST_ESC_END; end
                        CH_QUOTE, CH_BSL, CH_SLASH:
                                  begin emit = 1'b1; cp = {13'd0, in_byte}; end
                        CH_B:     begin emit = 1'b1; cp = 21'h08; end
                        CH_F:     begin emit = 1'b1; cp = 21'h0C; end
                        CH_N:     begin emit = 1'b1; cp = 21'h0A; end
                        CH_R:     begin emit = 1'b1; cp = 21'h0D; end
                        CH_T:     begin emit = 1'b1; cp = 21'h09; end
                        CH_U:
                        begin
                            phase_next = PH_HEX;
                            accum_next = '0;
                            cnt_next   = '0;
                        end
                        default:  begin fin = 1'b1; fin_st = ST_BAD_ESC; end
                    endcase
                end
                PH_HEX, PH_HEXLO:
                begin
                    priority if (!digit[4]) begin
                        fin    = 1'b1;
                        fin_st = (phase_reg == PH_HEX) ? ST_BAD_U : ST_BAD_PAIR;
                    end else if (cnt_reg != 2'd3) begin
                        accum_next = v;
                        cnt_next   = cnt_reg + 2'd1;
                    end else if (phase_reg == PH_HEX) begin
                        priority if (v >= 16'hD800 && v <= 16'hDBFF) begin
                            high_next  = v[9:0];   // v - 0xD800
                            accum_next = '0;
                            cnt_next   = '0;
                            phase_next = PH_BSL;
                        end else if (v >= 16'hDC00) begin
                            // v <= 0xDFFF here or above; only the low range is an error
                            if (v <= 16'hDFFF) begin
                                fin = 1'b1; fin_st = ST_LONE_LOW;
                            end else begin
                                emit = 1'b1; cp = {5'd0, v};
                            end
                        end else begin
                            emit = 1'b1; cp = {5'd0, v};
                        end
                    end else begin
                        if (v < 16'hDC00 || v > 16'hDFFF) begin
                            fin = 1'b1; fin_st = ST_BAD_PAIR;
                        end else begin
                            // 0x10000 + (high << 10) + (v - 0xDC00)
                            cp        = 21'h10000 + {1'b0, high_reg, v[9:0]};
                            emit      = 1'b1;
                            high_next = '0;
                        end
                    end
                end
                PH_BSL:
                begin
                    if (in_byte != CH_BSL) begin
                        fin = 1'b1; fin_st = ST_BAD_PAIR;
                    end else begin
                        phase_next = PH_LU;
                    end
                end
                PH_LU:
                begin
                    if (in_byte != CH_U) begin
                        fin = 1'b1; fin_st = ST_BAD_PAIR;
                    end else begin
                        phase_next = PH_HEXLO;
                        accum_next = '0;
                        cnt_next   = '0;
                    end
                end
                default:
                begin
                    // idle, and the unused phase code
                    priority if (in_byte == CH_SPACE || in_byte == CH_TAB ||
                                 in_byte == CH_LF || in_byte == CH_CR) begin
                        phase_next = PH_IDLE;
                    end else if (in_byte == CH_QUOTE) begin
                        phase_next = PH_STR;
                        accum_next = '0;
                        cnt_next   = '0;
                        high_next  = '0;
                    end else begin
                        fin = 1'b1; fin_st = ST_NO_QUOTE;
                    end
                end
            endcase
        end

        if (fin)
        begin
            phase_next          = PH_IDLE;
            accum_next          = '0;
            cnt_next            = '0;
            high_next           = '0;
            push.valid          = 1'b1;
            push.entry.status   = fin_st;
        end
        else if (emit)
        begin
            phase_next = PH_STR;
            accum_next = '0;
            cnt_next   = '0;
            push.valid = 1'b1;
            if (raw)
            begin
                push.entry.status  = ST_DATA;
                push.entry.data[0] = in_byte;
            end
            else
            begin
                push.entry = utf8_entry(cp);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            accum_reg <= '0;
            cnt_reg   <= '0;
            high_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            accum_reg <= accum_next;
            cnt_reg   <= cnt_next;
            high_reg  <= high_next;
        end
    end

endmodule

/* rtl/jsu_queue.sv */
// Short command queue between front end and back end.
// Depends on jsu_pkg.
module jsu_queue
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  jsu_push_t  push,
    input  logic       pop,
    output logic       full,
    output logic       empty,
    output jsu_entry_t head
);

    jsu_entry_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]     cnt_reg, cnt_next;
    logic              do_pop;

    assign full   = (cnt_reg == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (push.valid ? Q_AW'(1) : Q_AW'(0));
        rd_ptr_next = rd_ptr_reg + (do_pop ? Q_AW'(1) : Q_AW'(0));
        cnt_next    = cnt_reg + (push.valid ? (Q_AW+1)'(1) : '0)
                              - (do_pop ? (Q_AW+1)'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/jsu_back.sv */
// Back end: walks the bytes of each queue entry into the output register.
// Depends on jsu_pkg; reads jsu_queue.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  jsu_entry_t head,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic [3:0] status,
    output logic       last
);

    logic [1:0] sub_reg, sub_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [3:0] status_reg;
    logic       last_reg;
    logic       load;
    logic       take;
    logic       is_last;

    assign load    = !valid_reg || !out_stall;
    assign take    = load && !empty;
    assign is_last = (sub_reg == head.last_idx);
    assign pop     = take && is_last;

    always_comb
    begin
        valid_next = valid_reg;
        sub_next   = sub_reg;
        if (load)
        begin
            valid_next = !empty;
        end
        if (take)
        begin
            sub_next = is_last ? 2'd0 : sub_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg   <= head.data[sub_reg];
            status_reg <= head.status;
            last_reg   <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sub_reg   <= sub_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule
